// ----- design/trial_division_prime_test_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the trial division prime test modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

// Condition implies property in the same cycle
`define TDP_ASSERT_SAME(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("tdp same-cycle check failed");

// Condition implies property in the following cycle
`define TDP_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("tdp next-cycle check failed");

`endif

// ----- design/tdp_pkg.sv -----
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared types and constants of the trial division prime test.
// ----------------------------------------------------------------------------
package tdp_pkg;

    // Row grouping register and counter widths
    localparam int GROUP_W = 5;
    localparam int COUNT_W = 4;
    localparam logic [GROUP_W-1:0] GROUP_RESET = 5'd5;
    localparam logic [GROUP_W-1:0] GROUP_MAX   = 5'd16;
    localparam logic [GROUP_W-1:0] GROUP_MIN   = 5'd1;

    // First trial divisor and its square
    localparam int FIRST_DIVISOR = 2;
    localparam int FIRST_SQUARE  = FIRST_DIVISOR * FIRST_DIVISOR;

    // Controller to divide datapath
    typedef struct packed {
        logic load;     // latch candidate, divisor back to first
        logic start;    // begin a remainder run with current divisor
        logic step;     // advance to next divisor and its square
    } t_dp_cmd;

    // Divide datapath to controller
    typedef struct packed {
        logic below_two;  // candidate has no trial divisor at all
        logic sq_gt;      // divisor squared exceeds candidate
        logic div_done;   // remainder unit idle, result valid
        logic rem_zero;   // last remainder is zero
    } t_dp_sts;

    // Controller to row / output stage
    typedef struct packed {
        logic deliver;  // load result word into output register
        logic prime;    // verdict of the finished candidate
    } t_row_cmd;

    // Row / output stage to controller
    typedef struct packed {
        logic out_free;  // output register can take a word this cycle
    } t_row_sts;

endpackage

// ----- design/tdp_divide.sv -----
// ----------------------------------------------------------------------------
// tdp_divide
// Candidate and divisor registers, running divisor square, and a
// restoring remainder unit that retires one dividend bit per cycle.
// ----------------------------------------------------------------------------
`include "trial_division_prime_test_defines.svh"

module tdp_divide #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [VALUE_WIDTH-1:0] i_candidate,
    input  tdp_pkg::t_dp_cmd       i_cmd,
    output tdp_pkg::t_dp_sts       o_sts
);

    localparam int SQ_W  = VALUE_WIDTH + 1;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] r_cand;
    logic [VALUE_WIDTH-1:0] r_div;
    logic [SQ_W-1:0]        r_sq;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] r_shift;
    logic [CNT_W-1:0]       r_cnt;

    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;
    logic                   fits;
    logic [VALUE_WIDTH-1:0] n_rem;
    logic                   busy;

    // One restoring step: shift next dividend bit in, subtract if it fits
    assign trial = {r_rem, r_shift[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = trial >= {1'b0, r_div};
    assign n_rem = fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
    assign busy  = r_cnt != CNT_W'(VALUE_WIDTH);

    // Candidate, divisor and square
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cand <= i_candidate;
            r_div  <= VALUE_WIDTH'(tdp_pkg::FIRST_DIVISOR);
            r_sq   <= SQ_W'(tdp_pkg::FIRST_SQUARE);
        end else if (i_cmd.step) begin
            // (d+1)^2 = d^2 + 2d + 1
            r_div <= r_div + VALUE_WIDTH'(1);
            r_sq  <= r_sq + {r_div, 1'b1};
        end
    end

    // Remainder unit bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_W'(VALUE_WIDTH);
        end else if (i_cmd.start) begin
            r_cnt <= '0;
        end else if (busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // Remainder unit data
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem   <= '0;
            r_shift <= r_cand;
        end else if (busy) begin
            r_rem   <= n_rem;
            r_shift <= {r_shift[VALUE_WIDTH-2:0], 1'b0};
        end
    end

    // Status to controller
    assign o_sts.below_two = r_cand < VALUE_WIDTH'(tdp_pkg::FIRST_DIVISOR);
    assign o_sts.sq_gt     = r_sq > {1'b0, r_cand};
    assign o_sts.div_done  = !busy;
    assign o_sts.rem_zero  = r_rem == '0;

    // A fresh run never reports done on its first cycle
    `TDP_ASSERT_NEXT(a_start_busy, i_cmd.start, !o_sts.div_done)

endmodule

// ----- design/tdp_row.sv -----
// ----------------------------------------------------------------------------
// tdp_row
// Group size register, prime count of the current row, and the output
// register that holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
`include "trial_division_prime_test_defines.svh"

module tdp_row (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tdp_pkg::GROUP_W-1:0]   i_group_size,
    input  tdp_pkg::t_row_cmd             i_cmd,
    output tdp_pkg::t_row_sts             o_sts,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_is_prime,
    output logic                          o_row_end
);

    logic [tdp_pkg::GROUP_W-1:0] r_group;
    logic [tdp_pkg::COUNT_W-1:0] r_count;
    logic                        r_valid;
    logic                        r_is_prime;
    logic                        r_row_end;

    logic [tdp_pkg::GROUP_W-1:0] eff_group;
    logic [tdp_pkg::GROUP_W-1:0] next_count;
    logic                        hit;

    // Group size register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group <= tdp_pkg::GROUP_RESET;
        end else if (i_cfg_valid) begin
            r_group <= i_group_size;
        end
    end

    // Zero acts as one, anything above the maximum saturates
    always_comb begin
        if (r_group == '0) begin
            eff_group = tdp_pkg::GROUP_MIN;
        end else if (r_group > tdp_pkg::GROUP_MAX) begin
            eff_group = tdp_pkg::GROUP_MAX;
        end else begin
            eff_group = r_group;
        end
    end

    assign next_count = {1'b0, r_count} + tdp_pkg::GROUP_W'(1);
    assign hit        = next_count >= eff_group;

    // Row count, advanced only by primes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.deliver && i_cmd.prime) begin
            r_count <= hit ? '0 : next_count[tdp_pkg::COUNT_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.deliver) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.deliver) begin
            r_is_prime <= i_cmd.prime;
            r_row_end  <= i_cmd.prime && hit;
        end
    end

    assign o_sts.out_free = !r_valid || i_ready;
    assign o_valid        = r_valid;
    assign o_is_prime     = r_is_prime;
    assign o_row_end      = r_row_end;

    // Checks
    `TDP_ASSERT_SAME(a_no_overwrite, i_cmd.deliver, o_sts.out_free)
    `TDP_ASSERT_SAME(a_row_end_prime, r_valid && r_row_end, r_is_prime)
    `TDP_ASSERT_NEXT(a_count_hold, i_cmd.deliver && !i_cmd.prime, $stable(r_count))

endmodule

// ----- design/tdp_ctrl.sv -----
// ----------------------------------------------------------------------------
// tdp_ctrl
// Sequencer of the prime test: accepts a candidate, walks the trial
// divisors through the remainder unit and hands the verdict to the
// output stage.
// ----------------------------------------------------------------------------
`include "trial_division_prime_test_defines.svh"

module tdp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tdp_pkg::t_dp_sts  i_dp_sts,
    output tdp_pkg::t_dp_cmd  o_dp_cmd,
    input  tdp_pkg::t_row_sts i_row_sts,
    output tdp_pkg::t_row_cmd o_row_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_prime;
    logic   n_prime;
    logic   finish_wait;

    // Next state and commands
    always_comb begin
        n_state   = r_state;
        n_prime   = r_prime;
        o_ready   = 1'b0;
        o_dp_cmd  = '0;
        o_row_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_dp_cmd.load = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_dp_sts.below_two) begin
                    n_prime = 1'b0;
                    n_state = S_FINISH;
                end else if (i_dp_sts.sq_gt) begin
                    // no divisor up to the square root
                    n_prime = 1'b1;
                    n_state = S_FINISH;
                end else begin
                    o_dp_cmd.start = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                if (i_dp_sts.div_done) begin
                    if (i_dp_sts.rem_zero) begin
                        n_prime = 1'b0;
                        n_state = S_FINISH;
                    end else begin
                        o_dp_cmd.step = 1'b1;
                        n_state       = S_CHECK;
                    end
                end
            end
            S_FINISH: begin
                if (i_row_sts.out_free) begin
                    o_row_cmd.deliver = 1'b1;
                    o_row_cmd.prime   = r_prime;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prime <= 1'b0;
        end else begin
            r_state <= n_state;
            r_prime <= n_prime;
        end
    end

    // Verdict waiting on a busy output register
    assign finish_wait = r_state == S_FINISH && !i_row_sts.out_free;

    // Checks
    `TDP_ASSERT_NEXT(a_accept_check, i_valid && o_ready, r_state == S_CHECK)
    `TDP_ASSERT_NEXT(a_finish_hold, finish_wait, r_state == S_FINISH && $stable(r_prime))
    `TDP_ASSERT_SAME(a_single_cmd, r_state == S_DIV, !o_dp_cmd.load && !o_dp_cmd.start)

endmodule

// ----- design/trial_division_prime_test.sv -----
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Trial division primality test with grouping of primes into rows.
// ----------------------------------------------------------------------------
// One candidate in, one result word out. A candidate n is tested against
// each trial divisor d = 2, 3, ... with d*d <= n, stopping early at the
// first divisor with zero remainder; each division runs through the
// remainder unit, which retires one dividend bit per cycle. Values 0 to 3
// finish without any division, and even numbers from 4 up stop at d = 2.
// One candidate is in work at a time; the output register lets the next
// one start while the previous word waits. row_end marks the prime that
// completes a row of group_size primes (0 reads as 1, above 16 reads as
// 16); group_size is to be written by the user only while the block is
// idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tdp_pkg::GROUP_W-1:0]   i_group_size,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [VALUE_WIDTH-1:0]        i_candidate,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_is_prime,
    output logic                          o_row_end
);

    tdp_pkg::t_dp_cmd  dp_cmd;
    tdp_pkg::t_dp_sts  dp_sts;
    tdp_pkg::t_row_cmd row_cmd;
    tdp_pkg::t_row_sts row_sts;

    // Sequencer
    tdp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_dp_sts  (dp_sts),
        .o_dp_cmd  (dp_cmd),
        .i_row_sts (row_sts),
        .o_row_cmd (row_cmd)
    );

    // Divisor walk and remainder unit
    tdp_divide #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_divide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_candidate (i_candidate),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts)
    );

    // Row count and output word
    tdp_row u_row (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_group_size (i_group_size),
        .i_cmd        (row_cmd),
        .o_sts        (row_sts),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_is_prime   (o_is_prime),
        .o_row_end    (o_row_end)
    );

endmodule
